// ===== rtl/core/avr_pkg.sv =====
// Package with the widths, sizes and raster constants of the attribute video raster.
package avr_pkg;

    localparam int unsigned ADDR_W       = 13;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned COLOR_W      = 3;
    localparam int unsigned GROUP_PIXELS = 8;
    localparam int unsigned COLORS_W     = COLOR_W * GROUP_PIXELS;
    localparam int unsigned X_W          = 9;
    localparam int unsigned Y_W          = 8;
    localparam int unsigned COL_W        = 6;
    localparam int unsigned ROW_W        = 8;

    localparam int unsigned BITMAP_DEPTH = 6144;
    localparam int unsigned ATTR_DEPTH   = 768;
    localparam int unsigned BITMAP_AW    = 13;
    localparam int unsigned ATTR_AW      = 10;

    localparam logic [ADDR_W-1:0] ATTR_BASE  = 13'd6144;
    localparam logic [ADDR_W-1:0] STORE_SIZE = 13'd6912;

    localparam logic [COL_W-1:0] COL_LAST      = 6'd39;
    localparam logic [COL_W-1:0] WIN_COL_FIRST = 6'd4;
    localparam logic [COL_W-1:0] WIN_COL_END   = 6'd36;
    localparam logic [ROW_W-1:0] ROW_LAST      = 8'd199;
    localparam logic [ROW_W-1:0] WIN_ROW_FIRST = 8'd4;
    localparam logic [ROW_W-1:0] WIN_ROW_END   = 8'd196;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    typedef logic [COLOR_W-1:0]  t_color;
    typedef logic [COLORS_W-1:0] t_colors;

endpackage

// ===== rtl/core/avr_if.sv =====
// Request and result channel interfaces of the attribute video raster.
interface avr_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [avr_pkg::ADDR_W-1:0]     store_address;
    logic [avr_pkg::DATA_W-1:0]     store_data;

    modport source (output valid, kind, store_address, store_data, input ready);
    modport sink   (input valid, kind, store_address, store_data, output ready);
endinterface

interface avr_out_if;
    logic                           valid;
    logic                           ready;
    logic [avr_pkg::X_W-1:0]        group_x;
    logic [avr_pkg::Y_W-1:0]        group_y;
    avr_pkg::t_colors               pixel_colors;
    logic                           frame_end;

    modport source (output valid, group_x, group_y, pixel_colors, frame_end, input ready);
    modport sink   (input valid, group_x, group_y, pixel_colors, frame_end, output ready);
endinterface

// ===== rtl/core/attribute_video_raster.sv =====
// Top level of the attribute video raster: video store, raster scan and pixel colouring.
// Each request either writes one byte of the 6912-byte video store or renders the next
// 8-pixel group of a 320x200 frame in raster order; only render requests give a result.
// The store is split into a bitmap memory and an attribute memory, so both bytes of a
// group are read in the cycle the request is taken; a request is accepted every clock while
// the sink does not stall, and a result passes the read registers and the output register,
// which holds it while the sink stalls. After reset a clearing pass zeroes both memories
// (6144 addresses), taking no request; the border colour register may be written meanwhile.
module attribute_video_raster (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [avr_pkg::COLOR_W-1:0]  i_cfg_data,
    avr_in_if.sink                       i_in,
    avr_out_if.source                    o_res
);

    logic [avr_pkg::DATA_W-1:0] bitmap_mem [avr_pkg::BITMAP_DEPTH];
    logic [avr_pkg::DATA_W-1:0] attr_mem   [avr_pkg::ATTR_DEPTH];

    avr_pkg::t_color                 r_border;
    logic                            r_clr_busy;
    logic [avr_pkg::BITMAP_AW-1:0]   r_clr_addr;
    logic [avr_pkg::COL_W-1:0]       r_col;
    logic [avr_pkg::ROW_W-1:0]       r_row;

    logic                            r_s1_valid;
    logic [avr_pkg::DATA_W-1:0]      r_bits;
    logic [avr_pkg::DATA_W-1:0]      r_attr;
    logic                            r_s1_window;
    logic                            r_s1_end;
    logic [avr_pkg::COL_W-1:0]       r_s1_col;
    logic [avr_pkg::ROW_W-1:0]       r_s1_row;

    logic                            r_out_valid;
    logic [avr_pkg::X_W-1:0]         r_out_x;
    logic [avr_pkg::Y_W-1:0]         r_out_y;
    avr_pkg::t_colors                r_out_colors;
    logic                            r_out_end;

    logic                            out_free;
    logic                            s1_move;
    logic                            accept;
    logic                            render_acc;
    logic                            write_acc;
    logic [4:0]                      win_col;
    logic [avr_pkg::ROW_W-1:0]       win_row;
    logic [avr_pkg::BITMAP_AW-1:0]   bitmap_rd_addr;
    logic [avr_pkg::ATTR_AW-1:0]     attr_rd_addr;
    logic [avr_pkg::ADDR_W-1:0]      attr_offset;
    logic                            in_window;
    logic                            bitmap_we;
    logic                            attr_we;
    logic [avr_pkg::BITMAP_AW-1:0]   bitmap_wr_addr;
    logic [avr_pkg::ATTR_AW-1:0]     attr_wr_addr;
    logic [avr_pkg::DATA_W-1:0]      wr_data;
    avr_pkg::t_colors                n_colors;

    assign out_free   = !r_out_valid || o_res.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_clr_busy && (!r_s1_valid || out_free);
    assign accept     = i_in.valid && i_in.ready;
    assign render_acc = accept && (i_in.kind == avr_pkg::KIND_RENDER);
    assign write_acc  = accept && (i_in.kind == avr_pkg::KIND_WRITE);

    assign win_col        = 5'(r_col - avr_pkg::WIN_COL_FIRST);
    assign win_row        = r_row - avr_pkg::WIN_ROW_FIRST;
    assign bitmap_rd_addr = {win_row, win_col};
    assign attr_rd_addr   = {win_row[7:3], win_col};
    assign in_window      = (r_col >= avr_pkg::WIN_COL_FIRST) && (r_col < avr_pkg::WIN_COL_END)
                         && (r_row >= avr_pkg::WIN_ROW_FIRST) && (r_row < avr_pkg::WIN_ROW_END);

    assign attr_offset = i_in.store_address - avr_pkg::ATTR_BASE;

    always_comb begin
        if (r_clr_busy) begin
            bitmap_we      = 1'b1;
            attr_we        = (r_clr_addr < avr_pkg::BITMAP_AW'(avr_pkg::ATTR_DEPTH));
            bitmap_wr_addr = r_clr_addr;
            attr_wr_addr   = r_clr_addr[avr_pkg::ATTR_AW-1:0];
            wr_data        = '0;
        end else begin
            bitmap_we      = write_acc && (i_in.store_address < avr_pkg::ATTR_BASE);
            attr_we        = write_acc && (i_in.store_address >= avr_pkg::ATTR_BASE)
                          && (i_in.store_address < avr_pkg::STORE_SIZE);
            bitmap_wr_addr = i_in.store_address;
            attr_wr_addr   = attr_offset[avr_pkg::ATTR_AW-1:0];
            wr_data        = i_in.store_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bitmap_we) begin
            bitmap_mem[bitmap_wr_addr] <= wr_data;
        end
        if (attr_we) begin
            attr_mem[attr_wr_addr] <= wr_data;
        end
        if (render_acc) begin
            r_bits <= bitmap_mem[bitmap_rd_addr];
            r_attr <= attr_mem[attr_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == avr_pkg::BITMAP_AW'(avr_pkg::BITMAP_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border <= '0;
        end else if (i_cfg_we) begin
            r_border <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (render_acc) begin
            if (r_col == avr_pkg::COL_LAST) begin
                r_col <= '0;
                r_row <= (r_row == avr_pkg::ROW_LAST) ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (render_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (render_acc) begin
            r_s1_window <= in_window;
            r_s1_end    <= (r_col == avr_pkg::COL_LAST) && (r_row == avr_pkg::ROW_LAST);
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
        end
    end

    always_comb begin
        for (int j = 0; j < avr_pkg::GROUP_PIXELS; j++) begin
            if (!r_s1_window) begin
                n_colors[j*avr_pkg::COLOR_W +: avr_pkg::COLOR_W] = r_border;
            end else if (r_bits[j]) begin
                n_colors[j*avr_pkg::COLOR_W +: avr_pkg::COLOR_W] = r_attr[2:0];
            end else begin
                n_colors[j*avr_pkg::COLOR_W +: avr_pkg::COLOR_W] = r_attr[6:4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_x      <= {r_s1_col, 3'b000};
            r_out_y      <= r_s1_row;
            r_out_colors <= n_colors;
            r_out_end    <= r_s1_end;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.group_x      = r_out_x;
    assign o_res.group_y      = r_out_y;
    assign o_res.pixel_colors = r_out_colors;
    assign o_res.frame_end    = r_out_end;

endmodule
